>>> rtl/led_pulse_item_encoder_unit_macros.svh
// Assertion helpers for the encoder modules.
`ifndef LED_PULSE_ITEM_ENCODER_UNIT_MACROS_SVH
`define LED_PULSE_ITEM_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPIE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpie_pkg.sv
package lpie_pkg;

    localparam int TICK_W = 15;
    localparam int CHUNK_W = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHUNK_W-1:0] MAX_CHUNK_LEN = 4'd8;

    localparam logic [2:0] REG_HIGH_TICKS_ZERO = 3'd0;
    localparam logic [2:0] REG_LOW_TICKS_ZERO  = 3'd1;
    localparam logic [2:0] REG_HIGH_TICKS_ONE  = 3'd2;
    localparam logic [2:0] REG_LOW_TICKS_ONE   = 3'd3;
    localparam logic [2:0] REG_CHUNK_LEN       = 3'd4;

    localparam logic [TICK_W-1:0]  RST_HIGH_TICKS_ZERO = 15'd16;
    localparam logic [TICK_W-1:0]  RST_LOW_TICKS_ZERO  = 15'd34;
    localparam logic [TICK_W-1:0]  RST_HIGH_TICKS_ONE  = 15'd32;
    localparam logic [TICK_W-1:0]  RST_LOW_TICKS_ONE   = 15'd18;
    localparam logic [CHUNK_W-1:0] RST_CHUNK_LEN       = 4'd8;

    // Bit-slot index of the end marker within one byte's run.
    localparam logic [3:0] MARKER_SLOT = 4'd8;
    localparam logic [3:0] LAST_BIT_SLOT = 4'd7;

    typedef struct packed {
        logic [TICK_W-1:0]  high_ticks_zero;
        logic [TICK_W-1:0]  low_ticks_zero;
        logic [TICK_W-1:0]  high_ticks_one;
        logic [TICK_W-1:0]  low_ticks_one;
        logic [CHUNK_W-1:0] chunk_len;
    } t_cfg;

    // Classified byte handed from front to back.
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       marker;
    } t_entry;

    // Queue status seen by its consumer and producer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/lpie_queue.sv
module lpie_queue
    import lpie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_entry  i_wdata,
    input  logic    i_rd,
    output t_entry  o_rdata,
    output t_q_stat o_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wp;
    logic [PTR_W-1:0]   n_rp;
    logic               wr_ok;
    logic               rd_ok;

    always_comb begin
        o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
        o_stat.empty = (r_cnt == '0);
        wr_ok = i_wr && !o_stat.full;
        rd_ok = i_rd && !o_stat.empty;
        n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        o_rdata = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) r_wp <= n_wp;
            if (rd_ok) r_rp <= n_rp;
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[r_wp] <= i_wdata;
    end

endmodule

>>> rtl/lpie_front.sv
module lpie_front
    import lpie_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [7:0]         i_pixel_byte,
    input  logic               i_frame_last,
    input  logic [CHUNK_W-1:0] i_chunk_len,
    input  t_q_stat            i_q_stat,
    output logic               o_q_wr,
    output t_entry             o_q_wdata
);

    logic [CHUNK_W-1:0] r_bytes_in_chunk;
    logic [CHUNK_W-1:0] eff_chunk;
    logic [CHUNK_W:0]   count;
    logic               marker;

    always_comb begin
        // Clamp the chunk length into 1..MAX_CHUNK_LEN.
        if (i_chunk_len == '0) begin
            eff_chunk = CHUNK_W'(1);
        end else if (i_chunk_len > MAX_CHUNK_LEN) begin
            eff_chunk = MAX_CHUNK_LEN;
        end else begin
            eff_chunk = i_chunk_len;
        end
        count  = {1'b0, r_bytes_in_chunk} + 1'b1;
        marker = i_frame_last || (count >= {1'b0, eff_chunk});
        o_q_wr = i_push && !i_q_stat.full;
        o_q_wdata.pixel_byte = i_pixel_byte;
        o_q_wdata.marker     = marker;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_chunk <= '0;
        end else if (o_q_wr) begin
            r_bytes_in_chunk <= marker ? '0 : count[CHUNK_W-1:0];
        end
    end

endmodule

>>> rtl/lpie_back.sv
module lpie_back
    import lpie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_entry      i_q_rdata,
    input  t_q_stat     i_q_stat,
    output logic        o_q_rd,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_pulse_item,
    output logic        o_end_marker,
    output logic        o_run_last
);

    `include "led_pulse_item_encoder_unit_macros.svh"

    logic        r_busy;
    logic [7:0]  r_byte;
    logic        r_marker;
    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic [31:0] r_item;
    logic        r_end;
    logic        r_run_last;

    logic [31:0] n_item;
    logic        n_end;
    logic        n_run_last;
    logic        fin;
    logic        adv;

    always_comb begin
        fin = ((r_idx == LAST_BIT_SLOT) && !r_marker) || (r_idx == MARKER_SLOT);
        adv = r_busy && (!r_out_valid || i_pop);
        // Take the next byte as soon as the current one hands over its last item.
        o_q_rd = !i_q_stat.empty && (!r_busy || (adv && fin));
        if (r_idx == MARKER_SLOT) begin
            n_item     = '0;
            n_end      = 1'b1;
            n_run_last = 1'b1;
        end else begin
            if (r_byte[7]) begin
                n_item = {1'b0, i_cfg.low_ticks_one, 1'b1, i_cfg.high_ticks_one};
            end else begin
                n_item = {1'b0, i_cfg.low_ticks_zero, 1'b1, i_cfg.high_ticks_zero};
            end
            n_end      = 1'b0;
            n_run_last = (r_idx == LAST_BIT_SLOT) && !r_marker;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_rd) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv) begin
                if (fin) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_byte   <= i_q_rdata.pixel_byte;
            r_marker <= i_q_rdata.marker;
        end else if (adv) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
        if (adv) begin
            r_item     <= n_item;
            r_end      <= n_end;
            r_run_last <= n_run_last;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_pulse_item = r_item;
    assign o_end_marker = r_end;
    assign o_run_last   = r_run_last;

    `LPIE_ASSERT_NOW(a_marker_slot_only_with_marker, r_busy && (r_idx == MARKER_SLOT), r_marker, "marker slot reached without marker")
    `LPIE_ASSERT_NOW(a_no_read_mid_byte, o_q_rd, !r_busy || (adv && fin), "queue read while byte still in flight")
    `LPIE_ASSERT_NEXT(a_marker_item_fields, adv && (r_idx == MARKER_SLOT), r_end && r_run_last && (r_item == '0), "end marker item malformed")

endmodule

>>> rtl/led_pulse_item_encoder_unit.sv
// Channel   | Direction | Handshake        | Payload
// ----------+-----------+------------------+----------------------------------------
// bytes     | in        | push / full      | i_pixel_byte, i_frame_last
// items     | out       | empty / pop      | o_pulse_item, o_end_marker, o_run_last
// config    | in        | i_cfg_we         | i_cfg_idx, i_cfg_wdata
//
// Each byte yields 8 items, 9 when an end marker follows; the back-end
// bit sequencer emits one item per cycle into a single output register while no
// unpopped item waits there. A two-entry queue between front and back lets the next
// byte be accepted while the current one is still being sent.
// Withholding pop freezes the sequencer; full rises once both queue entries wait.
// A pushed byte is held in the queue, then in the sequencer, ahead of its first item.
// Reset is synchronous, active low; it restores register defaults and empties all stages.
module led_pulse_item_encoder_unit
    import lpie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_pixel_byte,
    input  logic              i_frame_last,
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       o_pulse_item,
    output logic              o_end_marker,
    output logic              o_run_last,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [TICK_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    t_entry  q_wdata;
    t_entry  q_rdata;
    t_q_stat q_stat;
    logic    q_wr;
    logic    q_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_ticks_zero <= RST_HIGH_TICKS_ZERO;
            r_cfg.low_ticks_zero  <= RST_LOW_TICKS_ZERO;
            r_cfg.high_ticks_one  <= RST_HIGH_TICKS_ONE;
            r_cfg.low_ticks_one   <= RST_LOW_TICKS_ONE;
            r_cfg.chunk_len       <= RST_CHUNK_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HIGH_TICKS_ZERO: r_cfg.high_ticks_zero <= i_cfg_wdata;
                REG_LOW_TICKS_ZERO:  r_cfg.low_ticks_zero  <= i_cfg_wdata;
                REG_HIGH_TICKS_ONE:  r_cfg.high_ticks_one  <= i_cfg_wdata;
                REG_LOW_TICKS_ONE:   r_cfg.low_ticks_one   <= i_cfg_wdata;
                REG_CHUNK_LEN:       r_cfg.chunk_len       <= i_cfg_wdata[CHUNK_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    lpie_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_pixel_byte  (i_pixel_byte),
        .i_frame_last  (i_frame_last),
        .i_chunk_len   (r_cfg.chunk_len),
        .i_q_stat      (q_stat),
        .o_q_wr        (q_wr),
        .o_q_wdata     (q_wdata)
    );

    lpie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    lpie_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_rdata    (q_rdata),
        .i_q_stat     (q_stat),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_pulse_item (o_pulse_item),
        .o_end_marker (o_end_marker),
        .o_run_last   (o_run_last)
    );

    assign full = q_stat.full;

endmodule
